FILE: sv/fir_lpf_pkg.sv
`timescale 1ns / 1ps

package fir_lpf_pkg;

  localparam int MAX_TAPS  = 64;
  localparam int FRAC_BITS = 12;

  localparam int SAMPLE_W = 16;
  localparam int ACTION_W = 2;
  localparam int IDX_W    = 6;
  localparam int TAP_W    = 7;
  localparam int ADDR_W   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CNT_W    = $clog2(MAX_TAPS + 1);
  localparam int PROD_W   = 2 * SAMPLE_W;
  // only the low bits of the sum survive the shift and 16-bit wrap
  localparam int ACC_W    = SAMPLE_W + FRAC_BITS;

  localparam logic [ACTION_W-1:0] ACT_PUSH  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_COEF  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

  localparam logic [TAP_W-1:0] TAP_COUNT_RST = 7'd64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic              hist_we;
    logic [ADDR_W-1:0] hist_wa;
    logic              hist_clr;
    logic              coef_we;
    logic [ADDR_W-1:0] coef_wa;
    logic              rd_en;
    logic [ADDR_W-1:0] hist_ra;
    logic [ADDR_W-1:0] coef_ra;
  } mem_ctl_t;

endpackage

FILE: sv/fir_lpf_in_if.sv
`timescale 1ns / 1ps

interface fir_lpf_in_if;
  import fir_lpf_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [ACTION_W-1:0]        action;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic [IDX_W-1:0]           coef_index;
  logic signed [SAMPLE_W-1:0] coef_value;

  modport source (output valid, action, sample_in, coef_index, coef_value, input ready);
  modport sink   (input valid, action, sample_in, coef_index, coef_value, output ready);
endinterface

FILE: sv/fir_lpf_out_if.sv
`timescale 1ns / 1ps

interface fir_lpf_out_if;
  import fir_lpf_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;

  modport source (output valid, sample_out, input ready);
  modport sink   (input valid, sample_out, output ready);
endinterface

FILE: sv/fir_lpf_mem.sv
`timescale 1ns / 1ps

module fir_lpf_mem (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  fir_lpf_pkg::mem_ctl_t                   ctl,
  input  logic signed [fir_lpf_pkg::SAMPLE_W-1:0] sample_wd,
  input  logic signed [fir_lpf_pkg::SAMPLE_W-1:0] coef_wd,
  output logic signed [fir_lpf_pkg::SAMPLE_W-1:0] hist_q,
  output logic signed [fir_lpf_pkg::SAMPLE_W-1:0] coef_q,
  output logic                                    rd_vld
);
  import fir_lpf_pkg::*;

  logic signed [SAMPLE_W-1:0] hist_mem [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] coef_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]        hist_vld_r;
  logic [MAX_TAPS-1:0]        coef_vld_r;
  logic signed [SAMPLE_W-1:0] hist_raw_r;
  logic signed [SAMPLE_W-1:0] coef_raw_r;
  logic                       hist_ok_r;
  logic                       coef_ok_r;
  logic                       rd_vld_r;

  always_ff @(posedge clk) begin
    if (ctl.hist_we) begin
      hist_mem[ctl.hist_wa] <= sample_wd;
    end
    if (ctl.rd_en) begin
      hist_raw_r <= hist_mem[ctl.hist_ra];
      hist_ok_r  <= hist_vld_r[ctl.hist_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.coef_we) begin
      coef_mem[ctl.coef_wa] <= coef_wd;
    end
    if (ctl.rd_en) begin
      coef_raw_r <= coef_mem[ctl.coef_ra];
      coef_ok_r  <= coef_vld_r[ctl.coef_ra];
    end
  end

  // history entries never written since reset or clear, and coefficient entries never written since reset, read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_vld_r <= '0;
      coef_vld_r <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      if (ctl.hist_clr) begin
        hist_vld_r <= '0;
      end else if (ctl.hist_we) begin
        hist_vld_r[ctl.hist_wa] <= 1'b1;
      end
      if (ctl.coef_we) begin
        coef_vld_r[ctl.coef_wa] <= 1'b1;
      end
      rd_vld_r <= ctl.rd_en;
    end
  end

  assign hist_q = hist_ok_r ? hist_raw_r : '0;
  assign coef_q = coef_ok_r ? coef_raw_r : '0;
  assign rd_vld = rd_vld_r;

`ifndef SYNTHESIS
  a_clr_empties: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.hist_clr |=> hist_vld_r == '0)
    else $error("history valid bits not cleared");

  a_no_rd_during_wr: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.rd_en && (ctl.hist_we || ctl.coef_we || ctl.hist_clr)))
    else $error("store written while a tap read is in flight");
`endif

endmodule

FILE: sv/fir_lpf_mac.sv
`timescale 1ns / 1ps

module fir_lpf_mac (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    acc_clr,
  input  logic                                    in_vld,
  input  logic signed [fir_lpf_pkg::SAMPLE_W-1:0] hist_q,
  input  logic signed [fir_lpf_pkg::SAMPLE_W-1:0] coef_q,
  output logic                                    prod_vld,
  output logic signed [fir_lpf_pkg::SAMPLE_W-1:0] result
);
  import fir_lpf_pkg::*;

  logic signed [PROD_W-1:0] prod_full;
  logic [ACC_W-1:0]         prod_r;
  logic                     prod_vld_r;
  logic [ACC_W-1:0]         acc_r;
  logic [ACC_W-1:0]         acc_nxt;

  assign prod_full = hist_q * coef_q;
  assign acc_nxt   = acc_r + prod_r;

  always_ff @(posedge clk) begin
    if (in_vld) begin
      prod_r <= prod_full[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      acc_r      <= '0;
    end else begin
      prod_vld_r <= in_vld;
      if (acc_clr) begin
        acc_r <= '0;
      end else if (prod_vld_r) begin
        acc_r <= acc_nxt;
      end
    end
  end

  // arithmetic shift then 16-bit wrap: just a slice of the wrapped sum
  assign result   = acc_r[FRAC_BITS +: SAMPLE_W];
  assign prod_vld = prod_vld_r;

`ifndef SYNTHESIS
  a_clr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    acc_clr |-> !in_vld && !prod_vld_r)
    else $error("accumulator cleared with products in flight");
`endif

endmodule

FILE: sv/fir_lpf_ctrl.sv
`timescale 1ns / 1ps

module fir_lpf_ctrl (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [fir_lpf_pkg::ACTION_W-1:0]        in_action,
  input  logic [fir_lpf_pkg::IDX_W-1:0]           in_coef_index,
  input  logic                                    cfg_we,
  input  logic [fir_lpf_pkg::TAP_W-1:0]           cfg_wdata,
  input  logic                                    pipe_busy,
  input  logic signed [fir_lpf_pkg::SAMPLE_W-1:0] mac_result,
  output fir_lpf_pkg::mem_ctl_t                   mem_ctl,
  output logic                                    acc_clr,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [fir_lpf_pkg::SAMPLE_W-1:0] out_data
);
  import fir_lpf_pkg::*;

  state_t                     state_r, state_nxt;
  logic [TAP_W-1:0]           tap_count_r;
  logic [CNT_W-1:0]           taps_r, taps_nxt;
  logic [ADDR_W-1:0]          wp_r, wp_nxt;
  logic [ADDR_W-1:0]          p_r, p_nxt;
  logic [ADDR_W-1:0]          c_r, c_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_data_r, out_data_nxt;

  logic [CNT_W-1:0]  act_taps;
  logic [ADDR_W-1:0] ptr_start;
  logic [CNT_W-1:0]  ptr_inc;
  logic [ADDR_W-1:0] wp_push;
  logic              in_fire;
  logic              out_free;

  always_comb begin
    if (tap_count_r == '0) begin
      act_taps = CNT_W'(1);
    end else if (32'(tap_count_r) > MAX_TAPS) begin
      act_taps = CNT_W'(MAX_TAPS);
    end else begin
      act_taps = CNT_W'(tap_count_r);
    end
  end

  // pointer left beyond a shortened ring restarts at zero
  assign ptr_start = (32'(wp_r) < 32'(act_taps)) ? wp_r : '0;
  assign ptr_inc   = CNT_W'(ptr_start) + CNT_W'(1);
  assign wp_push   = (ptr_inc == act_taps) ? '0 : ptr_inc[ADDR_W-1:0];

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_action == ACT_PUSH) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (c_r == '0) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy && out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_ctl       = '0;
    acc_clr       = 1'b0;
    taps_nxt      = taps_r;
    wp_nxt        = wp_r;
    p_nxt         = p_r;
    c_nxt         = c_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_action)
            ACT_PUSH: begin
              mem_ctl.hist_we = 1'b1;
              mem_ctl.hist_wa = ptr_start;
              taps_nxt        = act_taps;
              wp_nxt          = wp_push;
              p_nxt           = ptr_start;
              c_nxt           = ADDR_W'(act_taps - CNT_W'(1));
              acc_clr         = 1'b1;
            end
            ACT_COEF: begin
              mem_ctl.coef_we = (32'(in_coef_index) < MAX_TAPS);
              mem_ctl.coef_wa = ADDR_W'(in_coef_index);
            end
            ACT_CLEAR: begin
              mem_ctl.hist_clr = 1'b1;
              wp_nxt           = '0;
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        // newest sample pairs with the last coefficient, walking back in time
        mem_ctl.rd_en   = 1'b1;
        mem_ctl.hist_ra = p_r;
        mem_ctl.coef_ra = c_r;
        c_nxt           = c_r - ADDR_W'(1);
        p_nxt           = (p_r == '0) ? ADDR_W'(taps_r - CNT_W'(1)) : p_r - ADDR_W'(1);
      end
      ST_DRAIN: begin
        if (!pipe_busy && out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = mac_result;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tap_count_r <= TAP_COUNT_RST;
      taps_r      <= CNT_W'(1);
      wp_r        <= '0;
      p_r         <= '0;
      c_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      taps_r      <= taps_nxt;
      wp_r        <= wp_nxt;
      p_r         <= p_nxt;
      c_r         <= c_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        tap_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_busy_after_push: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_action == ACT_PUSH |=> !in_ready)
    else $error("ready while a push is being filtered");

  a_ring_addr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> 32'(p_r) < 32'(taps_r) && 32'(c_r) < 32'(taps_r))
    else $error("tap address outside the active ring");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRAIN && state_nxt == ST_IDLE |=> out_valid_r)
    else $error("filter finished without presenting a result");
`endif

endmodule

FILE: sv/fir_lowpass_filter_core.sv
`timescale 1ns / 1ps
// A push is read tap by tap in RUN; DRAIN then waits for the read and product registers to
// empty and the output to be free. One MAC per tap through a single shared multiplier.
// No request is taken until a push ends; coef writes, clears and unused codes give no result.
// Reset (synchronous, rst_n low): tap count 64, pointer zero, history and coefficients
// read as zero through per-entry valid bits; no clearing pass is needed.
module fir_lowpass_filter_core (
  input  logic                            clk,
  input  logic                            rst_n,
  fir_lpf_in_if.sink                      in_chan,
  fir_lpf_out_if.source                   out_chan,
  input  logic                            cfg_we,
  input  logic [fir_lpf_pkg::TAP_W-1:0]   cfg_wdata
);
  import fir_lpf_pkg::*;

  mem_ctl_t                   mem_ctl;
  logic                       acc_clr;
  logic                       rd_vld;
  logic                       prod_vld;
  logic signed [SAMPLE_W-1:0] hist_q;
  logic signed [SAMPLE_W-1:0] coef_q;
  logic signed [SAMPLE_W-1:0] mac_result;

  fir_lpf_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_chan.valid),
    .in_ready      (in_chan.ready),
    .in_action     (in_chan.action),
    .in_coef_index (in_chan.coef_index),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .pipe_busy     (rd_vld || prod_vld),
    .mac_result    (mac_result),
    .mem_ctl       (mem_ctl),
    .acc_clr       (acc_clr),
    .out_valid     (out_chan.valid),
    .out_ready     (out_chan.ready),
    .out_data      (out_chan.sample_out)
  );

  fir_lpf_mem u_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (mem_ctl),
    .sample_wd (in_chan.sample_in),
    .coef_wd   (in_chan.coef_value),
    .hist_q    (hist_q),
    .coef_q    (coef_q),
    .rd_vld    (rd_vld)
  );

  fir_lpf_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc_clr  (acc_clr),
    .in_vld   (rd_vld),
    .hist_q   (hist_q),
    .coef_q   (coef_q),
    .prod_vld (prod_vld),
    .result   (mac_result)
  );

endmodule
